>>> rtl/assert_macros.svh
// Assertion macros shared by the code/symbol bit packer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge while reset is released.
`define CSBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define CSBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CSBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/csbp_pkg.sv
// Package for the code/symbol bit packer: field widths, opcodes and the job
// record passed from the front end to the byte emitter. No dependencies.
package csbp_pkg;

  localparam int unsigned CODE_W        = 16;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned CODE_BITS_W   = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PEND_W        = 7;
  localparam int unsigned PEND_CNT_W    = 3;
  localparam int unsigned MAX_CODE_BITS = 16;
  // Hard cap on code bits so a pair never yields more than four bytes.
  localparam int unsigned CODE_CAP      = 24;
  localparam int unsigned ACC_W         = PEND_W + CODE_CAP + SYM_W;
  localparam int unsigned JOB_BYTES     = ACC_W / BYTE_W;
  localparam int unsigned JOB_CNT_W     = $clog2(JOB_BYTES + 1);
  localparam int unsigned SH_W          = $clog2(ACC_W + 1);
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [0:0] {
    OP_PAIR  = 1'b0,
    OP_FLUSH = 1'b1
  } csbp_op_e;

  // Bytes to emit, earliest byte in the low bits, and how many of them.
  typedef struct packed {
    logic [JOB_BYTES*BYTE_W-1:0] data;
    logic [JOB_CNT_W-1:0]        nbytes;
  } csbp_job_t;

endpackage

>>> rtl/csbp_ifs.sv
// Valid/ready channel interfaces for the code/symbol bit packer.
// Depends on csbp_pkg for the payload widths.
interface csbp_in_if;
  import csbp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [CODE_W-1:0]      code;
  logic [SYM_W-1:0]       sym;
  logic [CODE_BITS_W-1:0] code_bits;

  modport source (output valid, opcode, code, sym, code_bits, input ready);
  modport sink   (input valid, opcode, code, sym, code_bits, output ready);
endinterface

interface csbp_out_if;
  import csbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

>>> rtl/csbp_front.sv
// Front end of the bit packer: accepts items, merges code and symbol bits
// with the pending bits and queues byte jobs. Depends on csbp_pkg, csbp_ifs.
`include "assert_macros.svh"

module csbp_front #(
  parameter int unsigned MaxCodeBits = csbp_pkg::MAX_CODE_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  csbp_in_if.sink             in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output csbp_pkg::csbp_job_t job_o
);
  import csbp_pkg::*;

  localparam int unsigned CapBits = (MaxCodeBits < CODE_CAP) ? MaxCodeBits : CODE_CAP;

  logic [PEND_W-1:0]     pend_q, pend_d;
  logic [PEND_CNT_W-1:0] pc_q, pc_d;

  logic                   fire;
  logic [CODE_BITS_W-1:0] n_eff;
  logic [CODE_W-1:0]      code_m;
  logic [SH_W-1:0]        sym_pos;
  logic [SH_W-1:0]        total;
  logic [JOB_CNT_W-1:0]   nbytes;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       rem;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;

  // Bit merge for a pair item.
  always_comb begin
    if (in_i.code_bits > CODE_BITS_W'(CapBits)) begin
      n_eff = CODE_BITS_W'(CapBits);
    end else begin
      n_eff = in_i.code_bits;
    end
    for (int i = 0; i < CODE_W; i++) begin
      code_m[i] = in_i.code[i] && (CODE_BITS_W'(i) < n_eff);
    end
    sym_pos = SH_W'(pc_q) + SH_W'(n_eff);
    total   = sym_pos + SH_W'(SYM_W);
    nbytes  = JOB_CNT_W'(total >> 3);
    acc     = ACC_W'(pend_q) | (ACC_W'(code_m) << pc_q) | (ACC_W'(in_i.sym) << sym_pos);
    rem     = acc >> (SH_W'(nbytes) << 3);
  end

  always_comb begin
    pend_d = pend_q;
    pc_d   = pc_q;
    push_o = 1'b0;
    job_o  = '0;
    unique case (csbp_op_e'(in_i.opcode))
      OP_PAIR: begin
        job_o.data   = acc[JOB_BYTES*BYTE_W-1:0];
        job_o.nbytes = nbytes;
        push_o       = fire;
        if (fire) begin
          pend_d = rem[PEND_W-1:0];
          pc_d   = total[PEND_CNT_W-1:0];
        end
      end
      OP_FLUSH: begin
        job_o.data   = (JOB_BYTES*BYTE_W)'(pend_q);
        job_o.nbytes = JOB_CNT_W'(1);
        push_o       = fire && (pc_q != '0);
        if (fire) begin
          pend_d = '0;
          pc_d   = '0;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pc_q   <= '0;
    end else begin
      pend_q <= pend_d;
      pc_q   <= pc_d;
    end
  end

  `CSBP_ASSERT(a_pend_clean, clk_i, rst_ni, (pend_q >> pc_q) == '0, "stale pending bits")
  `CSBP_ASSERT(a_job_size, clk_i, rst_ni, push_o |-> (job_o.nbytes != '0 && job_o.nbytes <= JOB_CNT_W'(JOB_BYTES)), "bad job size")
  `CSBP_ASSERT(a_pair_pushes, clk_i, rst_ni, (fire && in_i.opcode == OP_PAIR) |-> push_o, "pair item queued no job")
  `CSBP_ASSERT(a_flush_clears, clk_i, rst_ni, (fire && in_i.opcode == OP_FLUSH) |=> (pc_q == '0), "flush left bits pending")

endmodule

>>> rtl/csbp_queue.sv
// Short job queue between the packer front end and the byte emitter.
// Depends on csbp_pkg for the job record.
module csbp_queue #(
  parameter int unsigned Depth = csbp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csbp_pkg::csbp_job_t job_i,
  input  logic                pop_i,
  output csbp_pkg::csbp_job_t job_o,
  output logic                full_o,
  output logic                empty_o
);
  import csbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  csbp_job_t       slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

>>> rtl/csbp_back.sv
// Byte emitter of the bit packer: takes jobs from the queue and sends their
// bytes one per cycle while out_o is ready, from an output register. Depends on csbp_pkg, csbp_ifs.
`include "assert_macros.svh"

module csbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  csbp_pkg::csbp_job_t job_i,
  output logic                pop_o,
  csbp_out_if.source          out_o
);
  import csbp_pkg::*;

  logic [JOB_BYTES*BYTE_W-1:0] data_q, data_d;
  logic [JOB_CNT_W-1:0]        cnt_q, cnt_d;
  logic                        out_fire;

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = data_q[BYTE_W-1:0];
  assign out_o.last_of_run = (cnt_q == JOB_CNT_W'(1));
  assign out_fire          = out_o.valid && out_o.ready;

  // Load the next job when idle or as the last byte of the current one leaves.
  assign pop_o = !q_empty_i && ((cnt_q == '0) || (cnt_q == JOB_CNT_W'(1) && out_o.ready));

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    if (pop_o) begin
      data_d = job_i.data;
      cnt_d  = job_i.nbytes;
    end else if (out_fire) begin
      data_d = data_q >> BYTE_W;
      cnt_d  = cnt_q - JOB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  `CSBP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= JOB_CNT_W'(JOB_BYTES), "byte count overrun")
  `CSBP_ASSERT(a_pop_when_done, clk_i, rst_ni, pop_o |-> (cnt_q == '0 || out_fire), "job loaded over unsent bytes")
  `CSBP_ASSERT(a_load_shows, clk_i, rst_ni, pop_o |=> out_o.valid, "loaded job not presented")

endmodule

>>> rtl/code_symbol_bit_packer_top.sv
// Top level of the code/symbol bit packer: front end, job queue, byte emitter.
// Depends on csbp_pkg, csbp_ifs, csbp_front, csbp_queue and csbp_back.
//
//   Port   Dir  Carries                                   Accepted when
//   in_i   in   opcode, code, sym, code_bits per item     valid && ready
//   out_o  out  out_byte, last_of_run per result byte     valid && ready
//
// The front end takes one item per cycle whenever the job queue has room.
// The emitter sends one byte per cycle while out_o is ready, so a pair item
// yields one to three bytes with the default code width (three for a 16-bit
// code plus the 8-bit symbol, four only when MaxCodeBits allows 24 code
// bits), and a flush at most one; the output port sets the sustained rate.
// The first byte of an item is offered once its job has been written to the
// queue and then loaded into the emitter's output register.
// Reset clears the pending bits, the queue and the emitter at once.
// A stalled output fills the queue and then drops in_i.ready.
module code_symbol_bit_packer_top #(
  parameter int unsigned MaxCodeBits = csbp_pkg::MAX_CODE_BITS,
  parameter int unsigned QueueDepth  = csbp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csbp_in_if.sink    in_i,
  csbp_out_if.source out_o
);
  import csbp_pkg::*;

  // Jobs from the front end: whole bytes completed by one item.
  csbp_job_t push_job;
  csbp_job_t head_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  // Merges each item's bits with the pending bits and keeps the leftover.
  csbp_front #(
    .MaxCodeBits (MaxCodeBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Decouples item intake from byte output so each side stalls on its own.
  csbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Sends the queued bytes in stream order, marking each item's last byte.
  csbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .job_i     (head_job),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
